### rtl/core/rmfp_pkg.sv
// shared types and constants of the rotated monochrome frame buffer plotter
package rmfp_pkg;

  localparam int FB_BYTES    = 8192;
  localparam int MAX_DIM     = 256;
  localparam int BYTE_BITS   = 8;
  localparam int BYTE_SHIFT  = $clog2(BYTE_BITS);
  localparam logic [BYTE_BITS-1:0] MSB_MASK   = 8'h80;
  localparam logic [BYTE_BITS-1:0] FILL_RESET = 8'hFF;

  localparam int DIM_W     = 9;
  localparam int ROT_W     = 2;
  localparam int MIRROR_W  = 2;
  localparam int KIND_W    = 2;
  localparam int ADDR_W    = 13;
  localparam int CFG_IDX_W = 2;
  localparam int RAM_AW    = $clog2(FB_BYTES);
  localparam int CNT_W     = $clog2(FB_BYTES + 1);
  localparam int RB_W      = $clog2((MAX_DIM + BYTE_BITS - 1) / BYTE_BITS + 1);
  localparam int AF_W      = ((DIM_W + RB_W > CNT_W) ? DIM_W + RB_W : CNT_W) + 1;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [DIM_W-1:0] WIDTH_RESET  = 9'd200;
  localparam logic [DIM_W-1:0] HEIGHT_RESET = 9'd200;

  localparam logic [ROT_W-1:0] ROT_0   = 2'd0;
  localparam logic [ROT_W-1:0] ROT_90  = 2'd1;
  localparam logic [ROT_W-1:0] ROT_180 = 2'd2;
  localparam logic [ROT_W-1:0] ROT_270 = 2'd3;

  localparam int MIRROR_H_BIT = 0;
  localparam int MIRROR_V_BIT = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MEM_WIDTH   = 2'd0,
    CFG_MEM_HEIGHT  = 2'd1,
    CFG_ROTATION    = 2'd2,
    CFG_MIRROR_MODE = 2'd3
  } cfg_reg_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_PLOT  = 2'd0,
    KIND_READ  = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    OP_PLOT   = 2'd0,
    OP_READ   = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_REJECT = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    B_INIT  = 2'd0,
    B_IDLE  = 2'd1,
    B_READ  = 2'd2,
    B_CLEAR = 2'd3
  } back_state_e;

  typedef struct packed {
    op_e                  op;
    logic [ADDR_W-1:0]    addr;
    logic [BYTE_BITS-1:0] mask;
    logic                 set_bit;
    logic [BYTE_BITS-1:0] color;
    logic [CNT_W-1:0]     fill;
  } rmfp_cmd_t;

endpackage

### rtl/core/rmfp_if.sv
// handshake channels of the plotter: item input, result output, register writes
interface rmfp_in_if import rmfp_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [KIND_W-1:0]    kind;
  logic [DIM_W-1:0]     x_logical;
  logic [DIM_W-1:0]     y_logical;
  logic [BYTE_BITS-1:0] color;
  logic [ADDR_W-1:0]    read_addr;

  modport source (output valid, kind, x_logical, y_logical, color, read_addr, input ready);
  modport sink   (input valid, kind, x_logical, y_logical, color, read_addr, output ready);
endinterface

interface rmfp_out_if import rmfp_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 rejected;
  logic [ADDR_W-1:0]    byte_addr;
  logic [BYTE_BITS-1:0] byte_value;

  modport source (output valid, rejected, byte_addr, byte_value, input ready);
  modport sink   (input valid, rejected, byte_addr, byte_value, output ready);
endinterface

interface rmfp_cfg_if import rmfp_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DIM_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/core/rmfp_ram.sv
// generic single write port ram with registered read
module rmfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/rmfp_front.sv
// front end: configuration registers, rotation, mirroring, bounds checks and address
module rmfp_front import rmfp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  rmfp_in_if.sink    in_i,
  rmfp_cfg_if.sink   cfg_i,
  input  logic       init_busy_i,
  input  logic       queue_full_i,
  output logic       push_o,
  output rmfp_cmd_t  cmd_o
);

  logic [DIM_W-1:0]    mem_width_q, mem_height_q;
  logic [ROT_W-1:0]    rotation_q;
  logic [MIRROR_W-1:0] mirror_q;

  logic [DIM_W-1:0] w, h, lw, lh, px, py;
  logic [RB_W-1:0]  rb;
  logic [AF_W-1:0]  addr_full, used_full;
  logic             in_range, phys_ok, addr_ok;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mem_width_q  <= WIDTH_RESET;
      mem_height_q <= HEIGHT_RESET;
      rotation_q   <= ROT_0;
      mirror_q     <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.index))
        CFG_MEM_WIDTH:   mem_width_q  <= cfg_i.data;
        CFG_MEM_HEIGHT:  mem_height_q <= cfg_i.data;
        CFG_ROTATION:    rotation_q   <= cfg_i.data[ROT_W-1:0];
        CFG_MIRROR_MODE: mirror_q     <= cfg_i.data[MIRROR_W-1:0];
        default: ;
      endcase
    end
  end

  // geometry of the point
  always_comb begin
    w  = (mem_width_q > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : mem_width_q;
    h  = (mem_height_q > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : mem_height_q;
    rb = RB_W'((w + DIM_W'(BYTE_BITS - 1)) >> BYTE_SHIFT);
    lw = rotation_q[0] ? h : w;
    lh = rotation_q[0] ? w : h;
    in_range = (in_i.x_logical < lw) && (in_i.y_logical < lh);

    case (rotation_q)
      ROT_0: begin
        px = in_i.x_logical;
        py = in_i.y_logical;
      end
      ROT_90: begin
        px = w - in_i.y_logical - DIM_W'(1);
        py = in_i.x_logical;
      end
      ROT_180: begin
        px = w - in_i.x_logical - DIM_W'(1);
        py = h - in_i.y_logical - DIM_W'(1);
      end
      default: begin
        px = in_i.y_logical;
        py = h - in_i.x_logical - DIM_W'(1);
      end
    endcase
    if (mirror_q[MIRROR_H_BIT]) px = w - px - DIM_W'(1);
    if (mirror_q[MIRROR_V_BIT]) py = h - py - DIM_W'(1);

    phys_ok   = (px < w) && (py < h);
    addr_full = AF_W'(px >> BYTE_SHIFT) + AF_W'(py) * AF_W'(rb);
    addr_ok   = addr_full < AF_W'(FB_BYTES);
    used_full = AF_W'(rb) * AF_W'(h);
  end

  // classify the item for the back end
  always_comb begin
    cmd_o.op      = OP_REJECT;
    cmd_o.addr    = '0;
    cmd_o.mask    = MSB_MASK >> px[BYTE_SHIFT-1:0];
    cmd_o.set_bit = (in_i.color != '0);
    cmd_o.color   = in_i.color;
    cmd_o.fill    = (used_full > AF_W'(FB_BYTES)) ? CNT_W'(FB_BYTES) : CNT_W'(used_full);
    case (kind_e'(in_i.kind))
      KIND_PLOT: begin
        if (in_range && phys_ok && addr_ok) begin
          cmd_o.op   = OP_PLOT;
          cmd_o.addr = ADDR_W'(addr_full);
        end
      end
      KIND_READ: begin
        if (AF_W'(in_i.read_addr) < AF_W'(FB_BYTES)) begin
          cmd_o.op   = OP_READ;
          cmd_o.addr = in_i.read_addr;
        end
      end
      KIND_CLEAR: cmd_o.op = OP_CLEAR;
      default:    cmd_o.op = OP_REJECT;
    endcase
  end

  assign in_i.ready = !init_busy_i && !queue_full_i;
  assign push_o     = in_i.valid && in_i.ready;

endmodule

### rtl/core/rmfp_queue.sv
// short command queue between front and back end
module rmfp_queue import rmfp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  rmfp_cmd_t cmd_i,
  input  logic      pop_i,
  output rmfp_cmd_t cmd_o,
  output logic      full_o,
  output logic      empty_o
);

  rmfp_cmd_t         entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;

  function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
    ptr_next = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= ptr_next(wr_ptr_q);
      if (pop_i)  rd_ptr_q <= ptr_next(rd_ptr_q);
      if (push_i && !pop_i) begin
        count_q <= count_q + QCNT_W'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - QCNT_W'(1);
      end
    end
  end

  assign cmd_o   = entry_q[rd_ptr_q];
  assign full_o  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);

endmodule

### rtl/core/rmfp_back.sv
// back end: buffer initialization, read-modify-write, clear sweep and result register
module rmfp_back import rmfp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  rmfp_cmd_t  cmd_i,
  input  logic       empty_i,
  output logic       pop_o,
  output logic       init_busy_o,
  rmfp_out_if.source res_o
);

  back_state_e state_q, state_d;
  rmfp_cmd_t   cmd_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  logic                 out_valid_q;
  logic                 rejected_q;
  logic [ADDR_W-1:0]    addr_q;
  logic [BYTE_BITS-1:0] value_q;

  logic                 can_pop;
  logic                 load;
  logic                 load_rej;
  logic [ADDR_W-1:0]    load_addr;
  logic [BYTE_BITS-1:0] load_val;

  logic                 ram_we, ram_re;
  logic [RAM_AW-1:0]    ram_waddr, ram_raddr;
  logic [BYTE_BITS-1:0] ram_wdata, ram_rdata, new_byte;

  rmfp_ram #(
    .WIDTH (BYTE_BITS),
    .DEPTH (FB_BYTES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // take a command only when the result slot is free or draining now
  assign can_pop  = !empty_i && (!out_valid_q || res_o.ready);
  assign new_byte = cmd_q.set_bit ? (ram_rdata | cmd_q.mask) : (ram_rdata & ~cmd_q.mask);

  always_comb begin
    state_d = state_q;
    case (state_q)
      B_INIT: begin
        if (cnt_q == CNT_W'(FB_BYTES - 1)) state_d = B_IDLE;
      end
      B_IDLE: begin
        if (can_pop) begin
          case (cmd_i.op)
            OP_PLOT, OP_READ: state_d = B_READ;
            OP_CLEAR: begin
              if (cmd_i.fill != '0) state_d = B_CLEAR;
            end
            default: state_d = B_IDLE;
          endcase
        end
      end
      B_READ:  state_d = B_IDLE;
      B_CLEAR: begin
        if (cnt_q == cmd_q.fill - CNT_W'(1)) state_d = B_IDLE;
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_comb begin
    pop_o     = 1'b0;
    cnt_d     = cnt_q;
    ram_we    = 1'b0;
    ram_waddr = cnt_q[RAM_AW-1:0];
    ram_wdata = FILL_RESET;
    ram_re    = 1'b0;
    ram_raddr = RAM_AW'(cmd_i.addr);
    load      = 1'b0;
    load_rej  = 1'b0;
    load_addr = '0;
    load_val  = '0;
    case (state_q)
      B_INIT: begin
        ram_we = 1'b1;
        cnt_d  = cnt_q + CNT_W'(1);
      end
      B_IDLE: begin
        if (can_pop) begin
          pop_o = 1'b1;
          cnt_d = '0;
          case (cmd_i.op)
            OP_PLOT, OP_READ: ram_re = 1'b1;
            OP_CLEAR: begin
              // nothing to fill: report at once
              if (cmd_i.fill == '0) begin
                load     = 1'b1;
                load_val = cmd_i.color;
              end
            end
            default: begin
              load     = 1'b1;
              load_rej = 1'b1;
            end
          endcase
        end
      end
      B_READ: begin
        load      = 1'b1;
        load_addr = cmd_q.addr;
        if (cmd_q.op == OP_PLOT) begin
          ram_we    = 1'b1;
          ram_waddr = RAM_AW'(cmd_q.addr);
          ram_wdata = new_byte;
          load_val  = new_byte;
        end else begin
          load_val  = ram_rdata;
        end
      end
      B_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = cmd_q.color;
        cnt_d     = cnt_q + CNT_W'(1);
        if (cnt_q == cmd_q.fill - CNT_W'(1)) begin
          load     = 1'b1;
          load_val = cmd_q.color;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_INIT;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= load || (out_valid_q && !res_o.ready);
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cmd_q <= cmd_i;
    end
    if (load) begin
      rejected_q <= load_rej;
      addr_q     <= load_addr;
      value_q    <= load_val;
    end
  end

  assign init_busy_o      = (state_q == B_INIT);
  assign res_o.valid      = out_valid_q;
  assign res_o.rejected   = rejected_q;
  assign res_o.byte_addr  = addr_q;
  assign res_o.byte_value = value_q;

  a_load_into_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> (!out_valid_q || res_o.ready))
    else $error("result loaded over a pending transfer");

  a_no_pop_during_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_INIT) |-> !pop_o)
    else $error("command taken while the buffer is still being initialized");

  a_read_follows_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_READ) |-> $past(pop_o))
    else $error("read state entered without taking a command");

endmodule

### rtl/core/rotated_mono_framebuffer_plotter.sv
// Rotated monochrome frame buffer plotter, top level.
// Items arrive on in_i (valid/ready): plot (rotate, mirror, bounds check, set or
// clear one bit), read (one buffer byte) or clear (fill every byte in use).
// Each item yields one result transfer on res_o: rejected flag, byte address
// and byte value. Registers (width, height, rotation, mirror) are written on
// cfg_i, always ready; the user must write them only while the block is idle.
// The front end classifies an item in the cycle it is accepted and pushes it
// into a two-entry queue; the back end runs it against the single buffer ram.
// Back end per item: plot and read take a ram read, then write and result;
// rejected or unused kinds load the result on being taken; clear fills
// row_bytes * height bytes, one byte a cycle, with its result on the last.
// The block itself does not enforce the idle rule for register writes.
// After reset the back end sweeps all 8192 bytes to 0xFF, one per cycle;
// in_i.ready stays low until the sweep is done.
// A stalled receiver holds the result register; the queue still takes up to
// two more items before in_i.ready drops.
module rotated_mono_framebuffer_plotter import rmfp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  rmfp_in_if.sink    in_i,
  rmfp_out_if.source res_o,
  rmfp_cfg_if.sink   cfg_i
);

  logic      push, pop, full, empty, init_busy;
  rmfp_cmd_t cmd_in, cmd_head;

  rmfp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .cfg_i        (cfg_i),
    .init_busy_i  (init_busy),
    .queue_full_i (full),
    .push_o       (push),
    .cmd_o        (cmd_in)
  );

  rmfp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd_in),
    .pop_i   (pop),
    .cmd_o   (cmd_head),
    .full_o  (full),
    .empty_o (empty)
  );

  rmfp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_head),
    .empty_i     (empty),
    .pop_o       (pop),
    .init_busy_o (init_busy),
    .res_o       (res_o)
  );

endmodule

### sim/rmfp_checker.sv
// checker of the plotter: keeps its own frame buffer copy and compares every result transfer
module rmfp_checker import rmfp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  rmfp_in_if   in_mon,
  rmfp_out_if  res_mon,
  rmfp_cfg_if  cfg_mon,
  output int   fails_o,
  output int   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                 rejected;
    logic [ADDR_W-1:0]    byte_addr;
    logic [BYTE_BITS-1:0] byte_value;
  } byte_result_t;

  logic [BYTE_BITS-1:0] shadow_fb [FB_BYTES];
  logic [DIM_W-1:0]     geo_width;
  logic [DIM_W-1:0]     geo_height;
  logic [ROT_W-1:0]     geo_rot;
  logic [MIRROR_W-1:0]  geo_mirror;
  byte_result_t         expected_bytes_q [$];

  // applies one item to the shadow buffer and returns the result it must produce
  function automatic byte_result_t draw_pixel_op(input logic [KIND_W-1:0] kind,
                                                 input logic [DIM_W-1:0] xl,
                                                 input logic [DIM_W-1:0] yl,
                                                 input logic [BYTE_BITS-1:0] color,
                                                 input logic [ADDR_W-1:0] raddr);
    byte_result_t         res;
    int                   w, h, row_bytes, lw, lh, px, py, addr, used;
    logic [BYTE_BITS-1:0] mask;
    res.rejected   = 1'b1;
    res.byte_addr  = '0;
    res.byte_value = '0;
    w = (geo_width > MAX_DIM) ? MAX_DIM : int'(geo_width);
    h = (geo_height > MAX_DIM) ? MAX_DIM : int'(geo_height);
    row_bytes = (w + BYTE_BITS - 1) / BYTE_BITS;
    case (kind)
      KIND_PLOT: begin
        // odd quarter turns swap the logical width and height
        lw = geo_rot[0] ? h : w;
        lh = geo_rot[0] ? w : h;
        if (int'(xl) < lw && int'(yl) < lh) begin
          case (geo_rot)
            ROT_0: begin
              px = int'(xl);
              py = int'(yl);
            end
            ROT_90: begin
              px = w - int'(yl) - 1;
              py = int'(xl);
            end
            ROT_180: begin
              px = w - int'(xl) - 1;
              py = h - int'(yl) - 1;
            end
            default: begin
              px = int'(yl);
              py = h - int'(xl) - 1;
            end
          endcase
          if (geo_mirror[MIRROR_H_BIT]) px = w - px - 1;
          if (geo_mirror[MIRROR_V_BIT]) py = h - py - 1;
          addr = px / BYTE_BITS + py * row_bytes;
          if (px >= 0 && px < w && py >= 0 && py < h && addr < FB_BYTES) begin
            mask = MSB_MASK >> (px % BYTE_BITS);
            if (color == '0) begin
              shadow_fb[addr] = shadow_fb[addr] & ~mask;
            end else begin
              shadow_fb[addr] = shadow_fb[addr] | mask;
            end
            res.rejected   = 1'b0;
            res.byte_addr  = addr[ADDR_W-1:0];
            res.byte_value = shadow_fb[addr];
          end
        end
      end
      KIND_READ: begin
        if (int'(raddr) < FB_BYTES) begin
          res.rejected   = 1'b0;
          res.byte_addr  = raddr;
          res.byte_value = shadow_fb[raddr];
        end
      end
      KIND_CLEAR: begin
        used = row_bytes * h;
        if (used > FB_BYTES) used = FB_BYTES;
        for (int i = 0; i < used; i++) shadow_fb[i] = color;
        res.rejected   = 1'b0;
        res.byte_value = color;
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  task automatic check_field(input string field, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", field, want, got);
      fails_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    byte_result_t want;
    if (!rst_ni) begin
      for (int i = 0; i < FB_BYTES; i++) shadow_fb[i] = FILL_RESET;
      geo_width  = WIDTH_RESET;
      geo_height = HEIGHT_RESET;
      geo_rot    = ROT_0;
      geo_mirror = '0;
      expected_bytes_q.delete();
      fails_o   = 0;
      pending_o = 0;
    end else begin
      if (res_mon.valid && res_mon.ready) begin
        if (expected_bytes_q.size() == 0) begin
          $error("result transfer with nothing expected: addr %0h value %0h",
                 res_mon.byte_addr, res_mon.byte_value);
          fails_o++;
        end else begin
          want = expected_bytes_q.pop_front();
          check_field("rejected", want.rejected, res_mon.rejected);
          check_field("byte_addr", want.byte_addr, res_mon.byte_addr);
          check_field("byte_value", want.byte_value, res_mon.byte_value);
        end
      end
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          CFG_MEM_WIDTH:   geo_width  = cfg_mon.data;
          CFG_MEM_HEIGHT:  geo_height = cfg_mon.data;
          CFG_ROTATION:    geo_rot    = cfg_mon.data[ROT_W-1:0];
          CFG_MIRROR_MODE: geo_mirror = cfg_mon.data[MIRROR_W-1:0];
          default: begin
          end
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        expected_bytes_q.push_back(draw_pixel_op(in_mon.kind, in_mon.x_logical,
                                                 in_mon.y_logical, in_mon.color,
                                                 in_mon.read_addr));
      end
      pending_o = expected_bytes_q.size();
    end
  end

endmodule

### sim/rotated_mono_framebuffer_plotter_test.sv
// testbench top of the plotter: clock, reset, register phases, item stimulus and verdict
module rotated_mono_framebuffer_plotter_test;
  timeunit 1ns;
  timeprecision 1ps;
  import rmfp_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int RESET_CYCLES = 12;
  localparam int LONG_HOLD = 300;
  localparam int PRESSURE_ITEMS = 10;
  localparam int TAIL_CYCLES = 16;
  localparam int PHASES = 16;
  localparam int PHASE_ITEMS = 28;
  localparam int MAX_GAP = 8;
  localparam int MAX_BURST = 24;
  localparam int CHEAP_CLEAR = 1024;

  typedef enum int {SINK_OPEN, SINK_CHOPPY, SINK_SLOW} sink_mode_e;

  typedef struct packed {
    logic [KIND_W-1:0]    kind;
    logic [DIM_W-1:0]     x;
    logic [DIM_W-1:0]     y;
    logic [BYTE_BITS-1:0] color;
    logic [ADDR_W-1:0]    addr;
  } pixel_item_t;

  logic clk;
  logic rst_n;
  logic hold_req;
  logic hold_done;
  int   fail_total;
  int   in_flight;
  int   burst_left = 0;
  // logical area and bytes in use under the current registers, for shaping items
  int   lw_cur, lh_cur, used_cur;
  int   geo_w_list [PHASES] = '{200, 1, 256, 8, 9, 511, 0, 17, 16, 5, 33, 256, 1, 0, 0, 3};
  int   geo_h_list [PHASES] = '{200, 1, 256, 8, 3, 300, 17, 0, 16, 40, 7, 1, 256, 0, 0, 3};

  rmfp_in_if  in_ch ();
  rmfp_out_if res_ch ();
  rmfp_cfg_if cfg_ch ();

  rotated_mono_framebuffer_plotter u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .res_o  (res_ch),
    .cfg_i  (cfg_ch)
  );

  rmfp_checker u_checker (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .in_mon    (in_ch),
    .res_mon   (res_ch),
    .cfg_mon   (cfg_ch),
    .fails_o   (fail_total),
    .pending_o (in_flight)
  );

  initial begin : clock_gen
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("[rotated_mono_framebuffer_plotter] ERROR");
    $finish;
  end

  function automatic pixel_item_t item_of(input logic [KIND_W-1:0] kind,
                                          input logic [DIM_W-1:0] x,
                                          input logic [DIM_W-1:0] y,
                                          input logic [BYTE_BITS-1:0] color,
                                          input logic [ADDR_W-1:0] addr);
    pixel_item_t it;
    it.kind  = kind;
    it.x     = x;
    it.y     = y;
    it.color = color;
    it.addr  = addr;
    return it;
  endfunction

  // mostly plots inside the logical area, with reads, clears and noise mixed in
  function automatic pixel_item_t random_item();
    pixel_item_t it;
    int          pick;
    logic        do_read;
    it.kind  = KIND_PLOT;
    it.x     = DIM_W'($urandom);
    it.y     = DIM_W'($urandom);
    it.color = BYTE_BITS'($urandom);
    it.addr  = ADDR_W'($urandom);
    do_read  = 1'b0;
    pick = $urandom_range(99, 0);
    if (pick < 65) begin
      if (lw_cur > 0 && lh_cur > 0) begin
        it.x = DIM_W'($urandom_range(lw_cur - 1, 0));
        it.y = DIM_W'($urandom_range(lh_cur - 1, 0));
      end
      it.color = $urandom_range(1, 0) ? 8'h00 : BYTE_BITS'($urandom_range(255, 1));
    end else if (pick < 75) begin
      // anywhere in the field range, mostly off the area
    end else if (pick < 92) begin
      do_read = 1'b1;
    end else if (pick < 97) begin
      // big clears are slow, keep most of them on small areas
      if (used_cur <= CHEAP_CLEAR || $urandom_range(3, 0) == 0) begin
        it.kind = KIND_CLEAR;
      end else begin
        do_read = 1'b1;
      end
    end else begin
      it.kind = KIND_UNUSED;
    end
    if (do_read) begin
      it.kind = KIND_READ;
      if (used_cur > 0 && $urandom_range(3, 0) != 0) begin
        it.addr = ADDR_W'($urandom_range(used_cur - 1, 0));
      end
    end
    return it;
  endfunction

  task automatic push_item(input pixel_item_t it);
    @(negedge clk);
    in_ch.valid     = 1'b1;
    in_ch.kind      = it.kind;
    in_ch.x_logical = it.x;
    in_ch.y_logical = it.y;
    in_ch.color     = it.color;
    in_ch.read_addr = it.addr;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic offer(input pixel_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(MAX_GAP, 1);
      repeat (gap) begin
        @(negedge clk);
        in_ch.valid = 1'b0;
      end
      burst_left = $urandom_range(MAX_BURST, 1);
    end
    push_item(it);
    burst_left--;
  endtask

  task automatic drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (in_flight != 0) @(negedge clk);
    // a clear writes its last byte in the same cycle its result is loaded
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [DIM_W-1:0] value);
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = value;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic set_geometry(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                              input logic [ROT_W-1:0] rot, input logic [MIRROR_W-1:0] mir);
    int cw, ch;
    drain();
    write_reg(CFG_MEM_WIDTH, w);
    write_reg(CFG_MEM_HEIGHT, h);
    write_reg(CFG_ROTATION, DIM_W'(rot));
    write_reg(CFG_MIRROR_MODE, DIM_W'(mir));
    cw = (w > MAX_DIM) ? MAX_DIM : int'(w);
    ch = (h > MAX_DIM) ? MAX_DIM : int'(h);
    lw_cur = rot[0] ? ch : cw;
    lh_cur = rot[0] ? cw : ch;
    used_cur = ((cw + BYTE_BITS - 1) / BYTE_BITS) * ch;
    if (used_cur > FB_BYTES) used_cur = FB_BYTES;
  endtask

  initial begin : result_sink
    int         seg_len, held;
    sink_mode_e mode;
    res_ch.ready = 1'b0;
    hold_done    = 1'b0;
    forever begin
      seg_len = $urandom_range(40, 4);
      mode    = sink_mode_e'($urandom_range(2, 0));
      repeat (seg_len) begin
        @(negedge clk);
        if (hold_req && !hold_done) begin
          // long stall so the queue fills and the input side backs up
          res_ch.ready = 1'b0;
          held = 0;
          while (held < LONG_HOLD) begin
            @(negedge clk);
            held++;
          end
          hold_done = 1'b1;
        end
        case (mode)
          SINK_OPEN:   res_ch.ready = 1'b1;
          SINK_CHOPPY: res_ch.ready = 1'($urandom_range(1, 0));
          default:     res_ch.ready = ($urandom_range(3, 0) == 0);
        endcase
      end
    end
  end

  initial begin : stimulus
    int          ph, n;
    pixel_item_t it;
    rst_n           = 1'b0;
    hold_req        = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.kind      = KIND_PLOT;
    in_ch.x_logical = '0;
    in_ch.y_logical = '0;
    in_ch.color     = '0;
    in_ch.read_addr = '0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = CFG_MEM_WIDTH;
    cfg_ch.data     = '0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;

    // reset geometry: 200 x 200, no rotation, no mirror, 5000 bytes in use
    offer(item_of(KIND_READ, '0, '0, '0, '0));
    offer(item_of(KIND_READ, '1, '1, '1, '1));
    offer(item_of(KIND_PLOT, 0, 0, 8'h00, 0));
    offer(item_of(KIND_PLOT, 199, 199, 8'h00, 0));
    offer(item_of(KIND_PLOT, 200, 0, 8'hFF, 0));
    offer(item_of(KIND_PLOT, 0, 200, 8'hFF, 0));
    offer(item_of(KIND_PLOT, '1, '1, '1, '1));
    offer(item_of(KIND_PLOT, 0, 0, 8'h01, 0));
    offer(item_of(KIND_PLOT, 7, 0, 8'h00, 0));
    offer(item_of(KIND_PLOT, 199, 0, 8'h00, 0));
    offer(item_of(KIND_READ, 0, 0, 8'h00, 0));
    offer(item_of(KIND_UNUSED, '1, '1, '1, '1));
    offer(item_of(KIND_UNUSED, '0, '0, '0, '0));
    offer(item_of(KIND_CLEAR, 0, 0, 8'h00, 0));
    // last byte in use, then the first one past the cleared extent
    offer(item_of(KIND_READ, 0, 0, 8'h00, 4999));
    offer(item_of(KIND_READ, 0, 0, 8'h00, 5000));
    offer(item_of(KIND_PLOT, 3, 2, 8'h80, 0));
    offer(item_of(KIND_READ, 0, 0, 8'h00, 50));
    offer(item_of(KIND_CLEAR, 0, 0, 8'hA5, 0));
    offer(item_of(KIND_PLOT, 1, 0, 8'h00, 0));
    offer(item_of(KIND_READ, 0, 0, 8'h00, 8191));

    geo_w_list[13] = $urandom_range(64, 1);
    geo_h_list[13] = $urandom_range(64, 1);
    geo_w_list[14] = $urandom_range(256, 1);
    geo_h_list[14] = $urandom_range(24, 1);

    // every rotation against every mirror mode, each with its own size
    for (ph = 0; ph < PHASES; ph++) begin
      set_geometry(DIM_W'(geo_w_list[ph]), DIM_W'(geo_h_list[ph]),
                   ROT_W'(ph % 4), MIRROR_W'(ph / 4));
      if (ph == 0) hold_req = 1'b1;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        it = random_item();
        if (ph == 0 && n < PRESSURE_ITEMS) begin
          push_item(it);
        end else begin
          offer(it);
        end
      end
    end

    drain();
    if (fail_total == 0 && in_flight == 0) begin
      $display("[rotated_mono_framebuffer_plotter] OK");
    end else begin
      $display("[rotated_mono_framebuffer_plotter] ERROR");
    end
    $finish;
  end

endmodule
